// File: hw/rtl/nal_sps_dimension_parser_top_assert.svh
// Assertion macros shared by the parser modules.
`ifndef NAL_SPS_DIMENSION_PARSER_TOP_ASSERT_SVH
`define NAL_SPS_DIMENSION_PARSER_TOP_ASSERT_SVH

// Implication checked every cycle outside reset.
`define NSP_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define NSP_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/nsp_pkg.sv
// ----------------------------------------------------------------------------
// nsp_pkg
// Shared types and constants of the NAL unit SPS dimension parser.
// ----------------------------------------------------------------------------
package nsp_pkg;

  localparam logic [4:0]  NAL_SLICE     = 5'd1;
  localparam logic [4:0]  NAL_IDR       = 5'd5;
  localparam logic [4:0]  NAL_SPS       = 5'd7;
  localparam logic [4:0]  NAL_PPS       = 5'd8;
  localparam logic [7:0]  BASELINE_PROF = 8'd66;
  localparam logic [15:0] MB_PIXELS     = 16'd16;
  localparam logic [15:0] SIZE_LIMIT    = 16'd65520;
  localparam logic [15:0] FALLBACK_W    = 16'd1920;
  localparam logic [15:0] FALLBACK_H    = 16'd1080;

  // Configuration register indexes.
  localparam logic CFG_FALLBACK_W = 1'b0;
  localparam logic CFG_FALLBACK_H = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_HDR   = 2'd1;
  localparam logic [1:0] ST_ERR   = 2'd2;
  localparam logic [1:0] ST_FRAME = 2'd3;

  // Classified byte handed from the front part to the back part.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [2:0] pos;
    logic [4:0] kind;
  } nsp_item_t;

  // Result item.
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] pic_width;
    logic [15:0] pic_height;
    logic [7:0]  profile;
    logic [7:0]  level;
  } nsp_result_t;

  // Macroblock count to pixels, saturating.
  function automatic logic [15:0] mbs_to_pixels(input logic [31:0] ue);
    logic [36:0] px;
    px = ({5'd0, ue} + 37'd1) << 4;
    mbs_to_pixels = (px > {21'd0, SIZE_LIMIT}) ? SIZE_LIMIT : px[15:0];
  endfunction

endpackage

// File: hw/rtl/nsp_if.sv
// ----------------------------------------------------------------------------
// nsp_in_if / nsp_out_if
// Valid/ready channels for NAL bytes and parser results.
// ----------------------------------------------------------------------------
interface nsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] nal_byte;
  logic       last_byte;
  modport source (output valid, nal_byte, last_byte, input ready);
  modport sink (input valid, nal_byte, last_byte, output ready);
endinterface

interface nsp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] pic_width;
  logic [15:0] pic_height;
  logic [7:0]  profile;
  logic [7:0]  level;
  modport source (output valid, status, pic_width, pic_height, profile, level,
                  input ready);
  modport sink (input valid, status, pic_width, pic_height, profile, level,
                output ready);
endinterface

// File: hw/rtl/nsp_front.sv
// ----------------------------------------------------------------------------
// nsp_front
// Accepts NAL bytes, tracks the byte position and NAL type of each byte.
// ----------------------------------------------------------------------------
module nsp_front (
  input  logic             clk,
  input  logic             rst_n,
  nsp_in_if.sink           in_ch,
  output logic             item_valid,
  input  logic             item_ready,
  output nsp_pkg::nsp_item_t item
);
  import nsp_pkg::*;

  logic [2:0] pos_r, pos_nxt;
  logic [4:0] kind_r, kind_nxt;
  logic       take;

  assign in_ch.ready = item_ready;
  assign item_valid  = in_ch.valid;
  assign take        = in_ch.valid && item_ready;

  // Header byte sets the type; later bytes inherit it.
  always_comb begin
    item.data = in_ch.nal_byte;
    item.last = in_ch.last_byte;
    item.pos  = pos_r;
    item.kind = (pos_r == 3'd0) ? (in_ch.nal_byte[4:0]) : kind_r;
  end

  // Position counter saturates at four and restarts after the last byte.
  always_comb begin
    pos_nxt  = pos_r;
    kind_nxt = kind_r;
    if (take) begin
      kind_nxt = item.kind;
      if (in_ch.last_byte) pos_nxt = 3'd0;
      else if (pos_r < 3'd4) pos_nxt = pos_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      kind_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      kind_r <= kind_nxt;
    end
  end
endmodule

// File: hw/rtl/nsp_queue.sv
// ----------------------------------------------------------------------------
// nsp_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module nsp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_valid,
  output logic               wr_ready,
  input  nsp_pkg::nsp_item_t wr_item,
  output logic               rd_valid,
  input  logic               rd_ready,
  output nsp_pkg::nsp_item_t rd_item
);
  import nsp_pkg::*;

  `include "nal_sps_dimension_parser_top_assert.svh"

  nsp_item_t  mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_item  = mem_r[rp_r];
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_valid && rd_ready;

  // Storage.
  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_item;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

  `NSP_ASSERT_IMP(a_q_cnt, clk, rst_n, 1'b1, cnt_r <= 2'd2, "queue overfilled")
  `NSP_ASSERT_IMP(a_q_ptr, clk, rst_n, cnt_r == 2'd0 || cnt_r == 2'd2, wp_r == rp_r,
                  "queue pointers disagree with count")
  `NSP_ASSERT_NEXT(a_q_full, clk, rst_n, cnt_r == 2'd2 && !rd, cnt_r == 2'd2,
                   "full queue lost an entry")
endmodule

// File: hw/rtl/nsp_back.sv
// ----------------------------------------------------------------------------
// nsp_back
// Decodes baseline SPS Exp-Golomb fields eight bits a cycle while the output is not stalled, and builds results.
// ----------------------------------------------------------------------------
module nsp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  output logic               item_ready,
  input  nsp_pkg::nsp_item_t item,
  input  logic [15:0]        fallback_w,
  input  logic [15:0]        fallback_h,
  nsp_out_if.source          out_ch
);
  import nsp_pkg::*;

  `include "nal_sps_dimension_parser_top_assert.svh"

  logic [3:0]  step_r, step_nxt;
  logic [5:0]  zrun_r, zrun_nxt;
  logic [5:0]  sleft_r, sleft_nxt;
  logic [31:0] code_r, code_nxt;
  logic [15:0] w_r, w_nxt, h_r, h_nxt;
  logic [7:0]  prof_r, prof_nxt, lvl_r, lvl_nxt;
  logic        sv_r, sv_nxt, pv_r, pv_nxt;
  logic        ov_r, ov_nxt;
  nsp_result_t res_r, res_nxt;
  logic        take;

  assign item_ready = !ov_r || out_ch.ready;
  assign take       = item_valid && item_ready;

  assign out_ch.valid      = ov_r;
  assign out_ch.status     = res_r.status;
  assign out_ch.pic_width  = res_r.pic_width;
  assign out_ch.pic_height = res_r.pic_height;
  assign out_ch.profile    = res_r.profile;
  assign out_ch.level      = res_r.level;

  // Bit-serial decode unrolled over one byte, then end-of-NAL handling.
  always_comb begin
    logic        bitv;
    logic [1:0]  st;
    logic        done;
    logic [31:0] ue;
    step_nxt  = step_r;
    zrun_nxt  = zrun_r;
    sleft_nxt = sleft_r;
    code_nxt  = code_r;
    w_nxt     = w_r;
    h_nxt     = h_r;
    prof_nxt  = prof_r;
    lvl_nxt   = lvl_r;
    sv_nxt    = sv_r;
    pv_nxt    = pv_r;
    ov_nxt    = ov_r && !out_ch.ready;
    res_nxt   = res_r;
    st        = ST_OK;
    bitv      = 1'b0;
    done      = 1'b0;
    ue        = '0;
    if (take) begin
      if (item.pos != 3'd0 && item.kind == NAL_SPS) begin
        if (item.pos == 3'd1) begin
          code_nxt = {24'd0, item.data};
        end else if (item.pos == 3'd3) begin
          prof_nxt  = code_r[7:0];
          lvl_nxt   = item.data;
          code_nxt  = '0;
          zrun_nxt  = '0;
          sleft_nxt = '0;
          step_nxt  = '0;
        end else if (item.pos == 3'd4 && prof_r == BASELINE_PROF) begin
          for (int i = 7; i >= 0; i--) begin
            bitv = item.data[i];
            done = 1'b0;
            if (step_nxt == 4'd5) begin
              step_nxt = 4'd6;
            end else if (step_nxt < 4'd8) begin
              if (code_nxt == '0) begin
                if (!bitv) begin
                  if (zrun_nxt < 6'd63) zrun_nxt = zrun_nxt + 6'd1;
                end else begin
                  code_nxt  = 32'd1;
                  sleft_nxt = zrun_nxt;
                  done      = (zrun_nxt == 6'd0);
                end
              end else begin
                code_nxt  = code_nxt[31] ? 32'hFFFF_FFFF : {code_nxt[30:0], bitv};
                sleft_nxt = sleft_nxt - 6'd1;
                done      = (sleft_nxt == 6'd0);
              end
              if (done) begin
                ue = code_nxt - 32'd1;
                case (step_nxt)
                  4'd2: begin
                    step_nxt = (ue == '0) ? 4'd3 : 4'd4;
                  end
                  4'd6: begin
                    w_nxt    = mbs_to_pixels(ue);
                    step_nxt = 4'd7;
                  end
                  4'd7: begin
                    h_nxt    = mbs_to_pixels(ue);
                    step_nxt = 4'd8;
                  end
                  default: step_nxt = step_nxt + 4'd1;
                endcase
                zrun_nxt  = '0;
                sleft_nxt = '0;
                code_nxt  = '0;
              end
            end
          end
        end
      end
      if (item.last) begin
        if (item.kind == NAL_SPS) begin
          if (item.pos < 3'd3) begin
            st = ST_ERR;
          end else begin
            if (prof_nxt == BASELINE_PROF) begin
              if (step_nxt <= 4'd6) w_nxt = MB_PIXELS;
              if (step_nxt <= 4'd7) h_nxt = MB_PIXELS;
            end else begin
              w_nxt = fallback_w;
              h_nxt = fallback_h;
            end
            sv_nxt = 1'b1;
            st     = ST_HDR;
          end
        end else if (item.kind == NAL_PPS) begin
          pv_nxt = 1'b1;
          st     = ST_HDR;
        end else if (item.kind == NAL_SLICE || item.kind == NAL_IDR) begin
          if (!sv_r || !pv_r) st = ST_ERR;
          else if (w_r != '0 && h_r != '0) st = ST_FRAME;
          else st = ST_OK;
        end
        step_nxt  = '0;
        zrun_nxt  = '0;
        sleft_nxt = '0;
        code_nxt  = '0;
        ov_nxt    = 1'b1;
        res_nxt   = '{st, w_nxt, h_nxt, prof_nxt, lvl_nxt};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      zrun_r  <= '0;
      sleft_r <= '0;
      code_r  <= '0;
      w_r     <= '0;
      h_r     <= '0;
      prof_r  <= '0;
      lvl_r   <= '0;
      sv_r    <= 1'b0;
      pv_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      zrun_r  <= zrun_nxt;
      sleft_r <= sleft_nxt;
      code_r  <= code_nxt;
      w_r     <= w_nxt;
      h_r     <= h_nxt;
      prof_r  <= prof_nxt;
      lvl_r   <= lvl_nxt;
      sv_r    <= sv_nxt;
      pv_r    <= pv_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  `NSP_ASSERT_IMP(a_b_step, clk, rst_n, 1'b1, step_r <= 4'd8, "field step out of range")
  `NSP_ASSERT_NEXT(a_b_res, clk, rst_n, take && item.last, ov_r,
                   "last byte gave no result")
  `NSP_ASSERT_IMP(a_b_frame, clk, rst_n, ov_r && res_r.status == ST_FRAME,
                  sv_r && pv_r, "frame ready without parameter sets")
endmodule

// File: hw/rtl/nal_sps_dimension_parser_top.sv
// ----------------------------------------------------------------------------
// nal_sps_dimension_parser_top
// Parses NAL units for SPS picture size, PPS presence and slice readiness.
// ----------------------------------------------------------------------------
// Channel | Direction | Contents
// in_     | sink      | nal_byte, last_byte per transfer
// out_    | source    | status, pic_width, pic_height, profile, level
// cfg_    | write     | index 0 fallback width, index 1 fallback height
//
// One byte per cycle sustained while the receiver is ready; the back part
// decodes all eight bits of a byte together in unrolled logic. The last
// byte of a unit passes through the queue, then into the output register.
// Synchronous active-low reset clears all state but queue and result data; fallback size 1920x1080.
// A two-entry queue and an output register let either side stall alone.
module nal_sps_dimension_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  nsp_in_if.sink      in_ch,
  nsp_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);
  import nsp_pkg::*;

  logic [15:0] fbw_r, fbh_r;
  logic        f_valid, f_ready, b_valid, b_ready;
  nsp_item_t   f_item, b_item;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fbw_r <= FALLBACK_W;
      fbh_r <= FALLBACK_H;
    end else if (cfg_we) begin
      if (cfg_index == CFG_FALLBACK_W) fbw_r <= cfg_wdata;
      if (cfg_index == CFG_FALLBACK_H) fbh_r <= cfg_wdata;
    end
  end

  nsp_front u_front (
    .clk, .rst_n, .in_ch,
    .item_valid(f_valid), .item_ready(f_ready), .item(f_item)
  );

  nsp_queue u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_item(b_item)
  );

  nsp_back u_back (
    .clk, .rst_n,
    .item_valid(b_valid), .item_ready(b_ready), .item(b_item),
    .fallback_w(fbw_r), .fallback_h(fbh_r), .out_ch
  );
endmodule

// File: sim/nsp_tb_if.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench channel note
// The byte and result channels come from the RTL interface file; the
// testbench instantiates them directly and adds nothing of its own here.
// ----------------------------------------------------------------------------

// File: sim/nsp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NAL parser result checker
// Watches the byte and result channels and the register write port, keeps its
// own copy of the parser state, predicts each status and compares every field.
// ----------------------------------------------------------------------------
module nsp_checker (
  input  logic        clk,
  input  logic        rst_n,
  nsp_in_if.sink      in_mon,
  nsp_out_if.sink     out_mon,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);
  import nsp_pkg::*;

  nsp_result_t status_queue[$];

  logic [15:0] fb_w, fb_h;
  logic [4:0]  kind;
  logic [2:0]  pos_cnt;
  logic [3:0]  step;
  logic [5:0]  zeros;
  logic [5:0]  suffix;
  logic [31:0] code;
  logic [15:0] width_px, height_px;
  logic [7:0]  prof, lvl;
  logic        sps_ok, pps_ok;

  function automatic logic [15:0] px_of(input logic [31:0] ue);
    logic [36:0] px;
    px = ({5'd0, ue} + 37'd1) * 37'd16;
    return (px > 37'd65520) ? 16'd65520 : px[15:0];
  endfunction

  // One Exp-Golomb bit of a baseline SPS.
  task automatic decode_bit(input logic bitv);
    logic [31:0] ue;
    if (step >= 4'd8) return;
    if (step == 4'd5) begin
      step = 4'd6;
      return;
    end
    if (code == 32'd0) begin
      if (!bitv) begin
        if (zeros < 6'd63) zeros = zeros + 6'd1;
        return;
      end
      code = 32'd1;
      suffix = zeros;
    end else begin
      code = code[31] ? 32'hFFFF_FFFF : {code[30:0], bitv};
      suffix = suffix - 6'd1;
    end
    if (suffix == 6'd0) begin
      ue = code - 32'd1;
      case (step)
        4'd2: step = (ue == 32'd0) ? 4'd3 : 4'd4;
        4'd6: begin
          width_px = px_of(ue);
          step = 4'd7;
        end
        4'd7: begin
          height_px = px_of(ue);
          step = 4'd8;
        end
        default: step = step + 4'd1;
      endcase
      zeros = '0;
      suffix = '0;
      code = '0;
    end
  endtask

  // Byte transfer: update the state and queue a status on the last byte.
  task automatic take_byte(input logic [7:0] b, input logic last);
    logic [2:0] p;
    nsp_result_t r;
    p = pos_cnt;
    if (p == 3'd0) begin
      kind = b[4:0];
    end else if (kind == NAL_SPS) begin
      if (p == 3'd1) begin
        code = {24'd0, b};
      end else if (p == 3'd3) begin
        prof = code[7:0];
        lvl = b;
        code = '0;
        zeros = '0;
        suffix = '0;
        step = '0;
      end else if (p >= 3'd4 && prof == BASELINE_PROF) begin
        for (int i = 7; i >= 0; i--) decode_bit(b[i]);
      end
    end
    if (pos_cnt < 3'd4) pos_cnt = pos_cnt + 3'd1;
    if (!last) return;
    r.status = ST_OK;
    if (kind == NAL_SPS) begin
      if (p < 3'd3) begin
        r.status = ST_ERR;
      end else begin
        if (prof == BASELINE_PROF) begin
          if (step <= 4'd6) width_px = 16'd16;
          if (step <= 4'd7) height_px = 16'd16;
        end else begin
          width_px = fb_w;
          height_px = fb_h;
        end
        sps_ok = 1'b1;
        r.status = ST_HDR;
      end
    end else if (kind == NAL_PPS) begin
      pps_ok = 1'b1;
      r.status = ST_HDR;
    end else if (kind == NAL_SLICE || kind == NAL_IDR) begin
      if (!sps_ok || !pps_ok) r.status = ST_ERR;
      else if (width_px != 0 && height_px != 0) r.status = ST_FRAME;
      else r.status = ST_OK;
    end
    pos_cnt = '0;
    step = '0;
    zeros = '0;
    suffix = '0;
    code = '0;
    r.pic_width = width_px;
    r.pic_height = height_px;
    r.profile = prof;
    r.level = lvl;
    status_queue.push_back(r);
  endtask

  // Compare one result transfer with the oldest expectation.
  task automatic check_result();
    nsp_result_t e;
    if (status_queue.size() == 0) begin
      $error("unexpected result: status %0d", out_mon.status);
      fail_count++;
      return;
    end
    e = status_queue.pop_front();
    if (out_mon.status !== e.status) begin
      $error("status: expected %0d, got %0d", e.status, out_mon.status);
      fail_count++;
    end
    if (out_mon.pic_width !== e.pic_width) begin
      $error("pic_width: expected %0d, got %0d", e.pic_width, out_mon.pic_width);
      fail_count++;
    end
    if (out_mon.pic_height !== e.pic_height) begin
      $error("pic_height: expected %0d, got %0d", e.pic_height, out_mon.pic_height);
      fail_count++;
    end
    if (out_mon.profile !== e.profile) begin
      $error("profile: expected %0d, got %0d", e.profile, out_mon.profile);
      fail_count++;
    end
    if (out_mon.level !== e.level) begin
      $error("level: expected %0d, got %0d", e.level, out_mon.level);
      fail_count++;
    end
  endtask

  // Sample all channels at the rising edge, before the drivers change them.
  always @(posedge clk) begin
    if (!rst_n) begin
      fb_w = FALLBACK_W;
      fb_h = FALLBACK_H;
      kind = '0;
      pos_cnt = '0;
      step = '0;
      zeros = '0;
      suffix = '0;
      code = '0;
      width_px = '0;
      height_px = '0;
      prof = '0;
      lvl = '0;
      sps_ok = 1'b0;
      pps_ok = 1'b0;
      status_queue.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_FALLBACK_W) fb_w = cfg_wdata;
        else fb_h = cfg_wdata;
      end
      if (out_mon.valid && out_mon.ready) check_result();
      if (in_mon.valid && in_mon.ready) take_byte(in_mon.nal_byte, in_mon.last_byte);
    end
    pending = status_queue.size();
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NAL SPS dimension parser testbench
// Sends directed and random NAL units through the parser under bursty input
// and a stalling receiver, across several fallback sizes; the checker module
// predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import nsp_pkg::*;

  localparam int MAX_CYCLES = 400000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;
  int          fail_count;
  int          pending;
  int          cycle_cnt;
  int          burst_left;
  logic [7:0]  unit_bytes[$];

  nsp_in_if  in_ch ();
  nsp_out_if out_ch ();

  nal_sps_dimension_parser_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  nsp_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch.sink),
    .out_mon    (out_ch.sink),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Receiver stalls: alternating runs of steady ready and random ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (cycle_cnt[9:8] == 2'd1) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("nal_sps_dimension_parser_top: mismatch");
      $finish;
    end
  end

  // Send the queued bytes as one NAL unit with bursts and gaps.
  task automatic send_unit();
    int idx;
    idx = 0;
    while (idx < unit_bytes.size()) begin
      if (burst_left == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(0, 2) == 0 ? $urandom_range(1, 6) : 0) @(posedge clk);
        burst_left = $urandom_range(1, 20);
      end
      in_ch.valid     <= 1'b1;
      in_ch.nal_byte  <= unit_bytes[idx];
      in_ch.last_byte <= (idx == unit_bytes.size() - 1);
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      idx++;
      burst_left--;
    end
    in_ch.valid <= 1'b0;
  endtask

  // Append an Exp-Golomb code bit string to a bit queue.
  task automatic put_ue(inout bit bits[$], input int unsigned zeros,
                        input logic [31:0] suffix);
    for (int i = 0; i < zeros; i++) bits.push_back(1'b0);
    bits.push_back(1'b1);
    for (int i = zeros - 1; i >= 0; i--)
      bits.push_back(i < 32 ? suffix[i] : 1'($urandom_range(0, 1)));
  endtask

  // Build a baseline-style SPS with random code content.
  task automatic make_sps(input logic [7:0] prof, input bit clean);
    bit bits[$];
    int unsigned z;
    int nbytes;
    logic [7:0] b;
    unit_bytes = {};
    unit_bytes.push_back({3'($urandom_range(0, 7)), NAL_SPS});
    unit_bytes.push_back(prof);
    unit_bytes.push_back(8'($urandom_range(0, 255)));
    unit_bytes.push_back(8'($urandom_range(0, 255)));
    for (int f = 0; f < 8; f++) begin
      if (f == 5) begin
        bits.push_back(1'($urandom_range(0, 1)));
      end else begin
        z = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
        if (f == 2 && $urandom_range(0, 1)) z = 0;
        put_ue(bits, z, $urandom);
      end
    end
    if (!clean) bits = bits[0:$urandom_range(0, bits.size() - 1)];
    nbytes = (bits.size() + 7) / 8 + $urandom_range(0, 1);
    for (int i = 0; i < nbytes; i++) begin
      for (int k = 0; k < 8; k++)
        b[7 - k] = (i * 8 + k < bits.size()) ? bits[i * 8 + k] : 1'($urandom_range(0, 1));
      unit_bytes.push_back(b);
    end
  endtask

  task automatic make_simple(input logic [4:0] kind, input int len);
    unit_bytes = {};
    unit_bytes.push_back({3'($urandom_range(0, 7)), kind});
    for (int i = 1; i < len; i++) unit_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_unit();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) make_sps(($urandom_range(0, 4) != 0) ? BASELINE_PROF :
                           8'($urandom_range(0, 255)), $urandom_range(0, 4) != 0);
    else if (sel < 60) make_simple(NAL_PPS, $urandom_range(1, 4));
    else if (sel < 85) make_simple(($urandom_range(0, 1)) ? NAL_SLICE : NAL_IDR,
                                   $urandom_range(1, 6));
    else if (sel < 92) make_simple(NAL_SPS, $urandom_range(1, 3));
    else make_simple(5'($urandom_range(0, 31)), $urandom_range(1, 8));
    send_unit();
  endtask

  initial begin
    logic [15:0] size_set[4];
    rst_n = 1'b0;
    burst_left = 0;
    cfg_we = 1'b0;
    cfg_index = CFG_FALLBACK_W;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.nal_byte = '0;
    in_ch.last_byte = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: slice before any parameter set, short SPS, one-byte units.
    make_simple(NAL_SLICE, 3); send_unit();
    make_simple(NAL_SPS, 1); send_unit();
    make_simple(NAL_SPS, 3); send_unit();
    make_simple(5'd31, 1); send_unit();
    make_simple(NAL_PPS, 1); send_unit();
    make_simple(NAL_IDR, 2); send_unit();
    // Non-baseline SPS uses the reset fallback size.
    make_sps(8'd100, 1'b1); send_unit();
    make_simple(NAL_SLICE, 2); send_unit();
    // Baseline with all-zero bits: long prefix and truncated codes.
    unit_bytes = '{8'h67, BASELINE_PROF, 8'd30, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
    send_unit();
    // Baseline whose first data byte holds every field as a one-bit code.
    unit_bytes = '{8'hE7, BASELINE_PROF, 8'd255, 8'd255, 8'hFF, 8'h01, 8'h00, 8'h00,
                   8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'hFF};
    send_unit();
    make_sps(BASELINE_PROF, 1'b1); send_unit();
    make_sps(BASELINE_PROF, 1'b0); send_unit();
    make_simple(NAL_IDR, 1); send_unit();
    wait_idle();

    // Random phases over several fallback sizes, extremes included.
    size_set = '{16'd0, 16'hFFFF, 16'd1280, 16'd720};
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_FALLBACK_W, (ph < 4) ? size_set[ph] : 16'($urandom_range(0, 65535)));
      write_reg(CFG_FALLBACK_H, (ph < 4) ? size_set[3 - ph] : 16'($urandom_range(0, 65535)));
      for (int n = 0; n < 13; n++) begin
        random_unit();
        if (n == 6) wait_idle();
      end
      wait_idle();
    end

    // Tail: wait for the last results, then give the verdict.
    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("nal_sps_dimension_parser_top: match");
    end else begin
      $display("nal_sps_dimension_parser_top: mismatch");
    end
    $finish;
  end

endmodule
